// File: src/avsd_pkg.sv
// Shared types, widths and constants of the audio/video sync delay controller.
`default_nettype none

package avsd_pkg;

    // Default depth of the offset averaging window
    localparam int WINDOW_LEN_DEF = 16;

    // Field widths
    localparam int STAMP_W  = 33;
    localparam int PERIOD_W = 16;
    localparam int OFFSET_W = 18;
    localparam int CORR_W   = 21;
    localparam int DELAY_W  = 25;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    // Configuration register widths
    localparam int TENTHS_W = 8;
    localparam int GAIN_W   = 4;

    // Offset arithmetic
    localparam int DIFF_W = STAMP_W + 1;
    localparam logic signed [DIFF_W-1:0] OFFSET_LIMIT = 34'sd100000;
    localparam int MAG_W = 17;

    // Tenths unit: magnitude product, then floor(x / 10) as (x * RECIP_TENTH) >> RECIP_SHIFT,
    // exact for x below 2**26
    localparam int PROD_W      = 24;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_TENTH = 24'd13421773;
    localparam int RECIP_SHIFT = 27;
    localparam int QUOT_W      = 21;

    // Delay accumulation
    localparam int STEP_DIFF_W = 22;
    localparam int STEP_W      = 29;
    localparam int ACC_SUM_W   = 30;
    localparam int LIMIT_W     = 23;

    // Configuration reset values
    localparam logic [TENTHS_W-1:0] DROP_START_RST = 8'd80;
    localparam logic [TENTHS_W-1:0] DROP_END_RST   = 8'd20;
    localparam logic [TENTHS_W-1:0] CLAMP_LOW_RST  = 8'hFE;
    localparam logic [TENTHS_W-1:0] CLAMP_HIGH_RST = 8'h02;
    localparam logic [GAIN_W-1:0]   GAIN_RST       = 4'd1;
    localparam logic                USE_AVG_RST    = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DROP_START = 3'd0,
        REG_DROP_END   = 3'd1,
        REG_CLAMP_LOW  = 3'd2,
        REG_CLAMP_HIGH = 3'd3,
        REG_GAIN       = 3'd4,
        REG_USE_AVG    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [TENTHS_W-1:0] drop_start;
        logic [TENTHS_W-1:0] drop_end;
        logic [TENTHS_W-1:0] clamp_low;   // two's complement
        logic [TENTHS_W-1:0] clamp_high;  // two's complement
        logic [GAIN_W-1:0]   gain;
        logic                use_avg;
    } cfg_t;

    // Operations of the shared tenths unit, issued in this order
    typedef enum logic [2:0] {
        OP_CORR  = 3'd0,
        OP_LO    = 3'd1,
        OP_HI    = 3'd2,
        OP_START = 3'd3,
        OP_END   = 3'd4
    } calc_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OFFSET,
        S_UPDATE,
        S_START,
        S_CALC,
        S_WAIT,
        S_CLAMP,
        S_STEP,
        S_ACC,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic     capture;
        logic     offset_en;
        logic     update_en;
        logic     div_start;
        logic     calc_valid;
        calc_op_t calc_op;
        logic     clamp_en;
        logic     step_en;
        logic     acc_en;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic calc_busy;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: src/avsd_cfg.sv
// Configuration register file of the sync delay controller.
`default_nettype none

module avsd_cfg
    import avsd_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_DROP_START: cfg_next.drop_start = cfg_data[TENTHS_W-1:0];
                REG_DROP_END:   cfg_next.drop_end   = cfg_data[TENTHS_W-1:0];
                REG_CLAMP_LOW:  cfg_next.clamp_low  = cfg_data[TENTHS_W-1:0];
                REG_CLAMP_HIGH: cfg_next.clamp_high = cfg_data[TENTHS_W-1:0];
                REG_GAIN:       cfg_next.gain       = cfg_data[GAIN_W-1:0];
                REG_USE_AVG:    cfg_next.use_avg    = cfg_data[0];
                default:        cfg_next = cfg_reg;  // unmapped index: drop
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drop_start <= DROP_START_RST;
            cfg_reg.drop_end   <= DROP_END_RST;
            cfg_reg.clamp_low  <= CLAMP_LOW_RST;
            cfg_reg.clamp_high <= CLAMP_HIGH_RST;
            cfg_reg.gain       <= GAIN_RST;
            cfg_reg.use_avg    <= USE_AVG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: src/avsd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module avsd_div
    import avsd_pkg::*;
#(
    parameter int DIVIDEND_W = OFFSET_W + $clog2(WINDOW_LEN_DEF + 1),
    parameter int DIVISOR_W  = $clog2(WINDOW_LEN_DEF + 1)
)(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  wire [DIVIDEND_W-1:0]  dividend,
    input  wire [DIVISOR_W-1:0]   divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where the divisor fits
            rem_next  = fits ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : trial[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: src/avsd_dp.sv
// Datapath: offset, averaging window, tenths unit, hurry-up flag, delay and result register.
`default_nettype none

module avsd_dp
    import avsd_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire cfg_t                  cfg,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    input  wire [STAMP_W-1:0]          audio_stamp,
    input  wire [STAMP_W-1:0]          video_stamp,
    input  wire [PERIOD_W-1:0]         frame_period,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic signed [DELAY_W-1:0]  delay_value,
    output logic                       hurry_flag,
    output logic signed [OFFSET_W-1:0] average_offset,
    output logic signed [CORR_W-1:0]   stamp_correction
);

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W = OFFSET_W + CNT_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

    // ---------------- captured item ----------------
    logic [STAMP_W-1:0]  audio_reg, video_reg;
    logic [PERIOD_W-1:0] period_reg;

    // ---------------- offset ----------------
    logic signed [DIFF_W-1:0]   diff;
    logic signed [OFFSET_W-1:0] offset_next, offset_reg;

    assign diff = $signed({1'b0, audio_reg}) - $signed({1'b0, video_reg});

    always_comb
    begin
        if (audio_reg == '0 || diff > OFFSET_LIMIT || diff < -OFFSET_LIMIT)
            offset_next = '0;
        else
            offset_next = OFFSET_W'(diff);
    end

    // ---------------- averaging window ----------------
    logic signed [OFFSET_W-1:0] win_mem [WINDOW_LEN];
    logic signed [OFFSET_W-1:0] old_reg;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SUM_W-1:0]    off_ext, old_ext;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       full;

    assign full    = (cnt_reg == CNT_FULL);
    assign off_ext = SUM_W'(offset_reg);
    assign old_ext = full ? SUM_W'(old_reg) : SUM_W'(0);

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        if (cmd.update_en)
        begin
            sum_next = sum_reg + off_ext - old_ext;
            cnt_next = full ? cnt_reg : cnt_reg + 1'b1;
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        end
    end

    // Read entries are used only once the window is full, so every entry used was written
    always_ff @(posedge clk)
    begin
        if (cmd.offset_en)
            old_reg <= win_mem[pos_reg];
        if (cmd.update_en)
            win_mem[pos_reg] <= offset_reg;
    end

    // ---------------- average divider ----------------
    logic [SUM_W-1:0] sum_mag;
    logic [SUM_W-1:0] quotient;
    logic             div_busy;

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    avsd_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_mag),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // ---------------- tenths unit: stage 1 magnitude product ----------------
    logic [TENTHS_W-1:0]       op_a;
    logic [MAG_W-1:0]          op_b;
    logic                      op_neg;
    logic [MAG_W-1:0]          off_mag;
    logic [TENTHS_W-1:0]       low_mag, high_mag;
    logic [TENTHS_W+MAG_W-1:0] prod_full;
    logic [PROD_W-1:0]         prod_reg;
    logic                      neg1_reg;
    calc_op_t                  op1_reg;
    logic                      v1_reg;

    assign off_mag  = offset_reg[OFFSET_W-1] ? MAG_W'(-offset_reg) : MAG_W'(offset_reg);
    assign low_mag  = cfg.clamp_low[TENTHS_W-1]  ? -cfg.clamp_low  : cfg.clamp_low;
    assign high_mag = cfg.clamp_high[TENTHS_W-1] ? -cfg.clamp_high : cfg.clamp_high;

    always_comb
    begin
        unique case (cmd.calc_op)
            OP_CORR:
            begin
                op_a   = TENTHS_W'(cfg.gain);
                op_b   = off_mag;
                op_neg = offset_reg[OFFSET_W-1];
            end
            OP_LO:
            begin
                op_a   = low_mag;
                op_b   = MAG_W'(period_reg);
                op_neg = cfg.clamp_low[TENTHS_W-1];
            end
            OP_HI:
            begin
                op_a   = high_mag;
                op_b   = MAG_W'(period_reg);
                op_neg = cfg.clamp_high[TENTHS_W-1];
            end
            OP_START:
            begin
                op_a   = cfg.drop_start;
                op_b   = MAG_W'(period_reg);
                op_neg = 1'b0;
            end
            OP_END:
            begin
                op_a   = cfg.drop_end;
                op_b   = MAG_W'(period_reg);
                op_neg = 1'b0;
            end
            default:
            begin
                op_a   = '0;
                op_b   = '0;
                op_neg = 1'b0;
            end
        endcase
    end

    assign prod_full = (TENTHS_W + MAG_W)'(op_a) * (TENTHS_W + MAG_W)'(op_b);

    // ---------------- tenths unit: stage 2 divide by ten ----------------
    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [QUOT_W-1:0]         quot10;
    logic signed [QUOT_W:0]    quot10_ext;
    logic signed [CORR_W-1:0]  quot10_signed;

    assign recip_prod    = (PROD_W + RECIP_W)'(prod_reg) * (PROD_W + RECIP_W)'(RECIP_TENTH);
    assign quot10        = recip_prod[RECIP_SHIFT +: QUOT_W];
    assign quot10_ext    = $signed({1'b0, quot10});
    assign quot10_signed = neg1_reg ? CORR_W'(-quot10_ext) : CORR_W'(quot10_ext);

    logic signed [CORR_W-1:0] corr_raw_reg, lo_reg, hi_reg;
    logic [QUOT_W-1:0]        start_reg, end_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[PROD_W-1:0];
        neg1_reg <= op_neg;
        op1_reg  <= cmd.calc_op;
        if (v1_reg)
        begin
            unique case (op1_reg)
                OP_CORR:  corr_raw_reg <= quot10_signed;
                OP_LO:    lo_reg       <= quot10_signed;
                OP_HI:    hi_reg       <= quot10_signed;
                OP_START: start_reg    <= quot10;
                OP_END:   end_reg      <= quot10;
                default:  corr_raw_reg <= corr_raw_reg;
            endcase
        end
    end

    // ---------------- clamp, average sign, delay step, hurry-up ----------------
    logic signed [CORR_W-1:0]      corr_reg;
    logic signed [OFFSET_W-1:0]    avg_reg;
    logic signed [STEP_W-1:0]      step_reg;
    logic signed [STEP_DIFF_W-1:0] step_diff;
    logic signed [STEP_W-1:0]      step_ext;
    logic signed [OFFSET_W-1:0]    drop_off;
    logic signed [QUOT_W:0]        drop_ext, start_ext, end_ext;
    logic                          hurry_reg, hurry_next;

    assign step_diff = $signed(STEP_DIFF_W'(period_reg)) - STEP_DIFF_W'(corr_reg);
    assign step_ext  = STEP_W'(step_diff);

    assign drop_off  = cfg.use_avg ? avg_reg : offset_reg;
    assign drop_ext  = (QUOT_W + 1)'(drop_off);
    assign start_ext = $signed({1'b0, start_reg});
    assign end_ext   = $signed({1'b0, end_reg});

    always_comb
    begin
        hurry_next = hurry_reg;
        if (cmd.step_en)
        begin
            priority if (drop_ext > start_ext)
                hurry_next = 1'b1;
            else if (drop_ext < end_ext)
                hurry_next = 1'b0;
            else
                hurry_next = hurry_reg;  // inside the band: hold
        end
    end

    // ---------------- delay accumulation ----------------
    logic signed [DELAY_W-1:0]   acc_reg, acc_next;
    logic [LIMIT_W-1:0]          period100;
    logic signed [ACC_SUM_W-1:0] acc_sum, lim_lo, lim_hi;

    assign period100 = LIMIT_W'({period_reg, 6'b0}) + LIMIT_W'({period_reg, 5'b0})
                     + LIMIT_W'({period_reg, 2'b0});
    assign acc_sum   = ACC_SUM_W'(acc_reg) + ACC_SUM_W'(step_reg);
    assign lim_lo    = -$signed(ACC_SUM_W'(period100));
    assign lim_hi    = $signed(ACC_SUM_W'({period100, 1'b0}));

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_en)
        begin
            priority if (acc_sum < lim_lo)
                acc_next = DELAY_W'(lim_lo);
            else if (acc_sum > lim_hi)
                acc_next = DELAY_W'(lim_hi);
            else
                acc_next = DELAY_W'(acc_sum);
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            audio_reg  <= audio_stamp;
            video_reg  <= video_stamp;
            period_reg <= frame_period;
        end
        if (cmd.offset_en)
            offset_reg <= offset_next;
        if (cmd.clamp_en)
        begin
            priority if (corr_raw_reg < lo_reg)
                corr_reg <= lo_reg;
            else if (corr_raw_reg > hi_reg)
                corr_reg <= hi_reg;
            else
                corr_reg <= corr_raw_reg;
            avg_reg <= sum_reg[SUM_W-1] ? OFFSET_W'(-quotient) : OFFSET_W'(quotient);
        end
        if (cmd.step_en)
            step_reg <= (step_ext <<< 6) + (step_ext <<< 5) + (step_ext <<< 2);
        if (cmd.out_load)
        begin
            delay_value      <= acc_reg;
            hurry_flag       <= hurry_reg;
            average_offset   <= avg_reg;
            stamp_correction <= corr_reg;
        end
    end

    // ---------------- control and state registers ----------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            hurry_reg     <= 1'b0;
            acc_reg       <= '0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            hurry_reg <= hurry_next;
            acc_reg   <= acc_next;
            v1_reg    <= cmd.calc_valid;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stat.div_busy  = div_busy;
    assign stat.calc_busy = v1_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// File: src/avsd_ctrl.sv
// Controller state machine sequencing one frame through the datapath.
`default_nettype none

module avsd_ctrl
    import avsd_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    calc_op_t    op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_OFFSET;
                end
            end
            S_OFFSET:
            begin
                cmd.offset_en = 1'b1;
                state_next    = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update_en = 1'b1;
                state_next    = S_START;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                op_next       = OP_CORR;
                state_next    = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc_valid = 1'b1;
                cmd.calc_op    = op_reg;
                if (op_reg == OP_END)
                    state_next = S_WAIT;
                else
                    op_next = calc_op_t'(op_reg + 3'd1);
            end
            S_WAIT:
            begin
                if (!stat.div_busy && !stat.calc_busy)
                    state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp_en = 1'b1;
                state_next   = S_STEP;
            end
            S_STEP:
            begin
                cmd.step_en = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_CORR;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

`default_nettype wire

// File: src/av_sync_delay_controller.sv
// Top level of the audio/video sync delay controller.
//
// Use: one input transaction per video frame on the s_axis channel carries the audio
// timestamp, the video timestamp and the frame period. For each one the block returns
// exactly one result transaction on m_axis: the clamped presentation delay, the window
// average of the audio-video offset and the clamped correction in tdata, and the hurry-up
// flag in tuser. Registers are written through the cfg channel (index, data); cfg_ready is
// always high, and writes belong between frames while the block is idle.
// Average: the window average comes from a bit-serial divider over SUM_W =
// 18 + clog2(WINDOW_LEN + 1) bits, and that divider sets the pace; the five tenths products
// share one multiply-by-reciprocal unit and run while it works. One frame is handled at a
// time: the next one is accepted only once the result of the last is in the output register.
// Reset: clears the window, average state, hurry-up flag and delay, and loads the register
// defaults. The window memory itself is not cleared; its entries are used only once written.
// Stall: a finished result waits in the output register; the next frame is accepted and
// processed meanwhile, and only its hand-over waits until m_axis_tready takes the first.
`default_nettype none

module av_sync_delay_controller
    import avsd_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)(
    input  wire                     clk,
    input  wire                     rst_n,
    // Input frames
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire [IN_TDATA_W-1:0]    s_axis_tdata,   // audio_stamp[32:0], video_stamp[65:33],
                                                    // frame_period[81:66], zero fill
    // Results
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // delay_value[24:0], average_offset[42:25],
                                                    // stamp_correction[63:43]
    output logic [0:0]              m_axis_tuser,   // hurry_flag[0]
    // Register writes
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire [CFG_IDX_W-1:0]     cfg_index,
    input  wire [CFG_DATA_W-1:0]    cfg_data
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic signed [DELAY_W-1:0]  delay_value;
    logic                       hurry_flag;
    logic signed [OFFSET_W-1:0] average_offset;
    logic signed [CORR_W-1:0]   stamp_correction;

    // Register file: takes a write in every cycle
    avsd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: accepts a frame only when idle, then steps the datapath
    avsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: unpack the input transaction fields straight from tdata
    avsd_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .stat             (stat),
        .audio_stamp      (s_axis_tdata[STAMP_W-1:0]),
        .video_stamp      (s_axis_tdata[2*STAMP_W-1:STAMP_W]),
        .frame_period     (s_axis_tdata[2*STAMP_W+PERIOD_W-1:2*STAMP_W]),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .delay_value      (delay_value),
        .hurry_flag       (hurry_flag),
        .average_offset   (average_offset),
        .stamp_correction (stamp_correction)
    );

    // Pack the result transaction, first field in the lowest bits
    assign m_axis_tdata = {stamp_correction, average_offset, delay_value};
    assign m_axis_tuser = hurry_flag;

endmodule

`default_nettype wire
